/* design/rpt_pkg.sv */
package rpt_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TickW  = 10;
  localparam int unsigned LeftW  = 21;
  localparam int unsigned LoadW  = 19;

  localparam logic [KindW-1:0] KindRead  = 2'd0;
  localparam logic [KindW-1:0] KindWrite = 2'd1;
  localparam logic [KindW-1:0] KindTick  = 2'd2;

  // irq_flags / irq_enables bit positions
  localparam int unsigned FlagPa7   = 0;
  localparam int unsigned FlagTimer = 1;

  localparam logic [ByteW-1:0] TimerAllOnes = 8'hFF;

  typedef enum logic [3:0] {
    OpNop,
    OpRdFlags,
    OpRdTimer,
    OpRdPortA,
    OpRdDdrA,
    OpRdPortB,
    OpRdDdrB,
    OpWrTimer,
    OpWrEdge,
    OpWrOutA,
    OpWrDdrA,
    OpWrOutB,
    OpWrDdrB,
    OpTick
  } op_e;

  // one decoded item; arg carries data, pins, ticks or the timer preload
  typedef struct packed {
    op_e              op;
    logic             a3;
    logic [1:0]       sel;
    logic [LoadW-1:0] arg;
  } entry_t;

  function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
    logic [3:0] s;
    case (sel)
      2'd0:    s = 4'd0;
      2'd1:    s = 4'd3;
      2'd2:    s = 4'd6;
      default: s = 4'd10;
    endcase
    return s;
  endfunction

endpackage

/* design/rpt_req_if.sv */
interface rpt_req_if;
  import rpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [AddrW-1:0] addr;
  logic [ByteW-1:0] write_data;
  logic [ByteW-1:0] port_a_pins;
  logic [ByteW-1:0] port_b_pins;
  logic [TickW-1:0] tick_count;

  modport source (
    output valid, kind, addr, write_data, port_a_pins, port_b_pins, tick_count,
    input  ready
  );

  modport sink (
    input  valid, kind, addr, write_data, port_a_pins, port_b_pins, tick_count,
    output ready
  );
endinterface

/* design/rpt_rsp_if.sv */
interface rpt_rsp_if;
  import rpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic [ByteW-1:0] port_a_drive;
  logic [ByteW-1:0] port_b_drive;
  logic [ByteW-1:0] port_a_direction;
  logic [ByteW-1:0] port_b_direction;
  logic             irq_line;

  modport source (
    output valid, read_data, port_a_drive, port_b_drive, port_a_direction,
           port_b_direction, irq_line,
    input  ready
  );

  modport sink (
    input  valid, read_data, port_a_drive, port_b_drive, port_a_direction,
           port_b_direction, irq_line,
    output ready
  );
endinterface

/* design/rpt_front.sv */
module rpt_front (
  rpt_req_if.sink         req_i,
  input  logic            full_i,
  output logic            push_o,
  output rpt_pkg::entry_t entry_o
);
  import rpt_pkg::*;

  logic [3:0]       shift;
  logic [LoadW-1:0] load;

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  assign shift = prescale_shift(req_i.addr[1:0]);
  assign load  = (LoadW'(req_i.write_data) << shift) + LoadW'(1);

  always_comb begin
    entry_o     = '0;
    entry_o.op  = OpNop;
    entry_o.a3  = req_i.addr[3];
    entry_o.sel = req_i.addr[1:0];
    unique case (req_i.kind)
      KindRead: begin
        if (req_i.addr[2]) begin
          entry_o.op = req_i.addr[0] ? OpRdFlags : OpRdTimer;
        end else if (req_i.addr[1]) begin
          entry_o.op  = req_i.addr[0] ? OpRdDdrB : OpRdPortB;
          entry_o.arg = LoadW'(req_i.port_b_pins);
        end else begin
          entry_o.op  = req_i.addr[0] ? OpRdDdrA : OpRdPortA;
          entry_o.arg = LoadW'(req_i.port_a_pins);
        end
      end
      KindWrite: begin
        if (req_i.addr[2] && req_i.addr[4]) begin
          entry_o.op  = OpWrTimer;
          entry_o.arg = load;
        end else if (req_i.addr[2]) begin
          entry_o.op = OpWrEdge;
        end else begin
          unique case (req_i.addr[1:0])
            2'd0:    entry_o.op = OpWrOutA;
            2'd1:    entry_o.op = OpWrDdrA;
            2'd2:    entry_o.op = OpWrOutB;
            default: entry_o.op = OpWrDdrB;
          endcase
          entry_o.arg = LoadW'(req_i.write_data);
        end
      end
      KindTick: begin
        entry_o.op  = OpTick;
        entry_o.arg = LoadW'(req_i.tick_count);
      end
      default: entry_o.op = OpNop;
    endcase
  end

endmodule

/* design/rpt_queue.sv */
module rpt_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rpt_pkg::entry_t entry_i,
  output logic            full_o,
  output logic            avail_o,
  input  logic            pop_i,
  output rpt_pkg::entry_t entry_o
);
  import rpt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign avail_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o)
    else $error("pop from empty queue");
`endif

endmodule

/* design/rpt_core.sv */
module rpt_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  rpt_pkg::entry_t entry_i,
  output logic            pop_o,
  rpt_rsp_if.source       rsp_o
);
  import rpt_pkg::*;

  logic [ByteW-1:0] out_a_q, out_a_d, out_b_q, out_b_d;
  logic [ByteW-1:0] dir_a_q, dir_a_d, dir_b_q, dir_b_d;
  logic [ByteW-1:0] latch_a_q, latch_a_d, latch_b_q, latch_b_d;
  logic [1:0]       en_q, en_d, flags_q, flags_d;
  logic             edge_pos_q, edge_pos_d, pa7_prev_q, pa7_prev_d;
  logic [3:0]       shift_q, shift_d;
  logic             finishing_q, finishing_d;
  logic signed [LeftW-1:0] left_q, left_d, diff, folded;

  logic [ByteW-1:0] rd_q, rd_d, eff_a, eff_b;
  logic             valid_q, irq_q;
  logic [ByteW-1:0] rsp_out_a_q, rsp_out_b_q, rsp_dir_a_q, rsp_dir_b_q;
  logic [ByteW-1:0] timer_val;
  logic [LoadW-1:0] counted;
  logic             pa7_upd, pa7_bit, keep_tflag;

  assign pop_o = avail_i && (!valid_q || rsp_o.ready);

  assign counted    = left_q[LoadW-1:0] >> shift_q;
  assign timer_val  = finishing_q ? left_q[ByteW-1:0] : counted[ByteW-1:0];
  assign keep_tflag = finishing_q && (timer_val == TimerAllOnes);

  assign diff   = left_q - $signed({{(LeftW-TickW){1'b0}}, entry_i.arg[TickW-1:0]});
  // reduce a non-positive count into -255..0; the low byte is unchanged
  assign folded = (diff[ByteW-1:0] == '0) ? '0
                : {{(LeftW-ByteW){1'b1}}, diff[ByteW-1:0]};

  always_comb begin
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    dir_a_d     = dir_a_q;
    dir_b_d     = dir_b_q;
    latch_a_d   = latch_a_q;
    latch_b_d   = latch_b_q;
    en_d        = en_q;
    flags_d     = flags_q;
    edge_pos_d  = edge_pos_q;
    pa7_prev_d  = pa7_prev_q;
    shift_d     = shift_q;
    finishing_d = finishing_q;
    left_d      = left_q;
    rd_d        = '0;
    pa7_upd     = 1'b0;

    case (entry_i.op)
      OpRdFlags: begin
        rd_d             = {flags_q[FlagTimer], flags_q[FlagPa7], 6'b0};
        flags_d[FlagPa7] = 1'b0;
      end
      OpRdTimer: begin
        rd_d           = timer_val;
        en_d[FlagTimer] = entry_i.a3;
        if (!keep_tflag) begin
          flags_d[FlagTimer] = 1'b0;
        end
      end
      OpRdPortA: begin
        latch_a_d = entry_i.arg[ByteW-1:0];
        pa7_upd   = 1'b1;
      end
      OpRdDdrA:  rd_d = dir_a_q;
      OpRdPortB: latch_b_d = entry_i.arg[ByteW-1:0];
      OpRdDdrB:  rd_d = dir_b_q;
      OpWrTimer: begin
        shift_d         = prescale_shift(entry_i.sel);
        en_d[FlagTimer] = entry_i.a3;
        if (!keep_tflag) begin
          flags_d[FlagTimer] = 1'b0;
        end
        finishing_d = 1'b0;
        left_d      = LeftW'(entry_i.arg);
      end
      OpWrEdge: begin
        en_d[FlagPa7] = entry_i.sel[1];
        edge_pos_d    = entry_i.sel[0];
      end
      OpWrOutA: begin
        out_a_d = entry_i.arg[ByteW-1:0];
        pa7_upd = 1'b1;
      end
      OpWrDdrA: begin
        dir_a_d = entry_i.arg[ByteW-1:0];
        pa7_upd = 1'b1;
      end
      OpWrOutB: out_b_d = entry_i.arg[ByteW-1:0];
      OpWrDdrB: dir_b_d = entry_i.arg[ByteW-1:0];
      OpTick: begin
        if (finishing_q) begin
          left_d = folded;
          if (diff <= -21'sd256) begin
            flags_d[FlagTimer] = 1'b1;
          end
        end else if (diff <= 21'sd0) begin
          left_d             = folded;
          finishing_d        = 1'b1;
          flags_d[FlagTimer] = 1'b1;
        end else begin
          left_d = diff;
        end
      end
      default: ;
    endcase

    eff_a   = (out_a_d & dir_a_d) | (latch_a_d & ~dir_a_d);
    eff_b   = (out_b_d & dir_b_d) | (latch_b_d & ~dir_b_d);
    pa7_bit = eff_a[ByteW-1];
    if (pa7_upd) begin
      if (pa7_bit != pa7_prev_q && pa7_bit == edge_pos_q) begin
        flags_d[FlagPa7] = 1'b1;
      end
      pa7_prev_d = pa7_bit;
    end
    if (entry_i.op == OpRdPortA) begin
      rd_d = eff_a;
    end else if (entry_i.op == OpRdPortB) begin
      rd_d = eff_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_a_q     <= '0;
      out_b_q     <= '0;
      dir_a_q     <= '0;
      dir_b_q     <= '0;
      latch_a_q   <= '0;
      latch_b_q   <= '0;
      en_q        <= '0;
      flags_q     <= '0;
      edge_pos_q  <= 1'b0;
      pa7_prev_q  <= 1'b0;
      shift_q     <= 4'd10;
      finishing_q <= 1'b0;
      left_q      <= LeftW'(256) << 10;
      valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        out_a_q     <= out_a_d;
        out_b_q     <= out_b_d;
        dir_a_q     <= dir_a_d;
        dir_b_q     <= dir_b_d;
        latch_a_q   <= latch_a_d;
        latch_b_q   <= latch_b_d;
        en_q        <= en_d;
        flags_q     <= flags_d;
        edge_pos_q  <= edge_pos_d;
        pa7_prev_q  <= pa7_prev_d;
        shift_q     <= shift_d;
        finishing_q <= finishing_d;
        left_q      <= left_d;
        valid_q     <= 1'b1;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // result register, loaded with the state after the item
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q        <= rd_d;
      rsp_out_a_q <= out_a_d;
      rsp_out_b_q <= out_b_d;
      rsp_dir_a_q <= dir_a_d;
      rsp_dir_b_q <= dir_b_d;
      irq_q       <= |(flags_d & en_d);
    end
  end

  assign rsp_o.valid            = valid_q;
  assign rsp_o.read_data        = rd_q;
  assign rsp_o.port_a_drive     = rsp_out_a_q;
  assign rsp_o.port_b_drive     = rsp_out_b_q;
  assign rsp_o.port_a_direction = rsp_dir_a_q;
  assign rsp_o.port_b_direction = rsp_dir_b_q;
  assign rsp_o.irq_line         = irq_q;

`ifndef ASSERT_OFF
  a_finish_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finishing_q |-> (left_q <= 21'sd0 && left_q > -21'sd256))
    else $error("finishing count out of range");
  a_count_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finishing_q |-> left_q > 21'sd0)
    else $error("counting timer not positive");
  a_irq_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> irq_q == |(flags_q & en_q))
    else $error("irq line disagrees with flags and enables");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !rsp_o.ready) |-> !pop_o)
    else $error("result overwritten while stalled");
`endif

endmodule

/* design/riot_ports_timer_irq_unit.sv */
// 6532-style RIOT: two 8-bit ports with direction registers, an interval
// timer (prescale 1, 8, 64 or 1024) and a PA7 edge detector, both feeding
// one interrupt line through their enables.
//
// req_i carries one item per valid/ready handshake: a bus read, a bus write
// or a batch of timer ticks. rsp_o returns exactly one result per item, in
// order: the read byte (zero for writes and ticks), the port drive and
// direction registers and the interrupt level, all as they stand after the
// item.
//
// The front decodes an item in the accept cycle and pushes it into a small
// queue; the back executes one item per cycle into the result register,
// as long as rsp_o is not stalled. An accepted item passes through the
// queue and then the result register, which drives rsp_o.valid.
// When rsp_o stalls, the back holds its result and the queue keeps taking
// items until it holds QueueDepth of them, then req_i.ready drops.
// Reset clears ports, flags and enables and loads the timer with 256 at a
// prescale of 1024; no result is pending afterwards.
module riot_ports_timer_irq_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpt_req_if.sink   req_i,
  rpt_rsp_if.source rsp_o
);
  import rpt_pkg::*;

  entry_t front_entry, back_entry;
  logic   push, pop, full, avail;

  rpt_front u_front (
    .req_i   (req_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (front_entry)
  );

  rpt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .avail_o (avail),
    .pop_i   (pop),
    .entry_o (back_entry)
  );

  rpt_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .entry_i (back_entry),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule
